// File: design/pqr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqr_pkg: shared types and constants
// Request/result payload structs and command and result codes for the
// palette quantizer.
// ----------------------------------------------------------------------------
package pqr_pkg;

  localparam logic [2:0] CMD_WRITE    = 3'd0;
  localparam logic [2:0] CMD_CLASSIFY = 3'd1;
  localparam logic [2:0] CMD_TRAIN    = 3'd2;
  localparam logic [2:0] CMD_UPDATE   = 3'd3;
  localparam logic [2:0] CMD_EXPAND   = 3'd4;

  localparam logic [1:0] KIND_PACKED  = 2'd0;
  localparam logic [1:0] KIND_PIXEL   = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  localparam int CfgDataW = 13;
  localparam logic CFG_DEPTH = 1'b0;
  localparam logic CFG_WIDTH = 1'b1;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] packed_in;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] packed_out;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

// File: design/pqr_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqr_stream_if: valid/ready channel
// Carries one payload of type T with a source and a sink modport.
// ----------------------------------------------------------------------------
interface pqr_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/palette_quantizer_with_refinement_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// palette_quantizer_with_refinement_unit: nearest-color palette quantizer
// Classifies pixels against a palette, packs indices, expands bytes, and
// refines the palette from trained samples.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (write, classify, train, update, expand);
//   res carries packed bytes, expanded pixels or an update-done marker.
//   cfg_we/cfg_index/cfg_data write palette_depth (0) and line_width (1)
//   while the block is idle.
// Sequencing:
//   write and unknown commands finish in the idle state. classify: one
//   palette entry per cycle through a shared distance/compare unit; train
//   adds an accumulate step. expand: each pixel is read through the palette
//   memory read port, then waits until the result register drains. update:
//   per hit entry, three divisions in the shared divider, none for an entry
//   with no hits, then an accumulator clearing sweep after the done marker.
// Reset: a pass over every palette entry zeroes the accumulators; no request
//   is taken meanwhile. Palette entries are undefined until written.
// Stall: one request at a time; the result register holds while the
//   receiver stalls and the next request waits until it drains.
// ----------------------------------------------------------------------------
module palette_quantizer_with_refinement_unit #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_LINE_WIDTH  = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  pqr_stream_if.sink                      req,
  pqr_stream_if.source                    res,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [pqr_pkg::CfgDataW-1:0] cfg_data
);
  import pqr_pkg::*;

  localparam int IW = $clog2(PALETTE_ENTRIES);
  localparam int LW = $clog2(MAX_LINE_WIDTH + 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SCANW  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_EXRD   = 4'd6;
  localparam logic [3:0] S_EXOUT  = 4'd7;
  localparam logic [3:0] S_URD    = 4'd8;
  localparam logic [3:0] S_UDIV   = 4'd9;
  localparam logic [3:0] S_UWR    = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;
  localparam logic [3:0] S_WAIT   = 4'd12;

  // memories
  logic [23:0] pal_mem [PALETTE_ENTRIES];
  logic [23:0] rs_mem  [PALETTE_ENTRIES];
  logic [23:0] gs_mem  [PALETTE_ENTRIES];
  logic [23:0] bs_mem  [PALETTE_ENTRIES];
  logic [15:0] hc_mem  [PALETTE_ENTRIES];

  logic [3:0]    state;
  logic [3:0]    depth;
  logic [12:0]   width;
  req_t          cur;
  res_t          out_reg;
  logic          out_valid;
  logic [8:0]    scan;
  logic [IW-1:0] rd_addr;
  logic [23:0]   pal_q, rs_q, gs_q, bs_q;
  logic [15:0]   hc_q;
  logic          rd_valid;
  logic [IW-1:0] rd_idx;
  logic [17:0]   best;
  logic          best_ok;
  logic [IW-1:0] best_idx;
  logic [15:0]   samples;
  logic [7:0]    pack_shift;
  logic [3:0]    pack_pos;
  logic [LW-1:0] line_pos;
  logic [3:0]    slot;
  logic [1:0]    chan;
  logic [23:0]   avg;
  logic          div_start, div_done;
  logic          div_run;
  logic [7:0]    div_q;
  logic [23:0]   div_num;

  // effective configuration
  logic [3:0]    eff_depth;
  logic [LW-1:0] eff_width;
  logic [8:0]    active;
  logic [3:0]    spb;
  logic [3:0]    bits;
  always_comb begin
    eff_depth = (depth == 4'd0) ? 4'd1 : (depth > 4'd8) ? 4'd8 : depth;
    if (width == 13'd0) eff_width = LW'(1);
    else if (32'(width) > MAX_LINE_WIDTH) eff_width = LW'(MAX_LINE_WIDTH);
    else eff_width = LW'(width);
    active = (32'(9'd1 << eff_depth) > PALETTE_ENTRIES) ? 9'(PALETTE_ENTRIES)
           : (9'd1 << eff_depth);
    priority if (eff_depth == 4'd1) spb = 4'd8;
    else if (eff_depth == 4'd2) spb = 4'd4;
    else if (eff_depth <= 4'd4) spb = 4'd2;
    else spb = 4'd1;
    bits = (spb == 4'd8) ? 4'd1 : (spb == 4'd4) ? 4'd2 : (spb == 4'd2) ? 4'd4 : 4'd8;
  end

  // shared distance unit
  logic [7:0]  dr, dg, db;
  logic [17:0] sq_dist;
  always_comb begin
    dr = (pal_q[23:16] > cur.red)   ? pal_q[23:16] - cur.red   : cur.red   - pal_q[23:16];
    dg = (pal_q[15:8]  > cur.green) ? pal_q[15:8]  - cur.green : cur.green - pal_q[15:8];
    db = (pal_q[7:0]   > cur.blue)  ? pal_q[7:0]   - cur.blue  : cur.blue  - pal_q[7:0];
    sq_dist = 18'(16'(dr) * 16'(dr)) + 18'(16'(dg) * 16'(dg)) + 18'(16'(db) * 16'(db));
  end

  // expand slot index
  logic [7:0] ex_sel;
  logic [7:0] ex_idx;
  always_comb begin
    ex_sel = (cur.packed_in << (slot * bits)) >> (4'd8 - bits);
    ex_idx = ex_sel & 8'((9'd1 << eff_depth) - 9'd1);
  end

  // packed byte for classify
  logic [7:0] pk_next;
  logic [3:0] pp_next;
  logic [LW-1:0] lp_next;
  logic       eol;
  always_comb begin
    pk_next = (pack_shift << bits) | 8'(best_idx);
    pp_next = pack_pos + 4'd1;
    lp_next = line_pos + LW'(1);
    eol     = lp_next >= eff_width;
  end

  // division operand mux
  always_comb begin
    unique case (chan)
      2'd0:    div_num = rs_q;
      2'd1:    div_num = gs_q;
      default: div_num = bs_q;
    endcase
  end

  pqr_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(hc_q), .done(div_done), .quotient(div_q)
  );

  // memory read port
  always_ff @(posedge clk) begin
    pal_q <= pal_mem[rd_addr];
    rs_q  <= rs_mem[rd_addr];
    gs_q  <= gs_mem[rd_addr];
    bs_q  <= bs_mem[rd_addr];
    hc_q  <= hc_mem[rd_addr];
  end

  // memory write port
  logic          pal_we, acc_we;
  logic [IW-1:0] wr_addr;
  logic [23:0]   pal_wd, rs_wd, gs_wd, bs_wd;
  logic [15:0]   hc_wd;
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[wr_addr] <= pal_wd;
    if (acc_we) begin
      rs_mem[wr_addr] <= rs_wd;
      gs_mem[wr_addr] <= gs_wd;
      bs_mem[wr_addr] <= bs_wd;
      hc_mem[wr_addr] <= hc_wd;
    end
  end

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign res.valid = out_valid;
  assign res.data  = out_reg;

  logic accept;
  assign accept = req.valid && req.ready;

  // sequencer
  always_comb begin
    pal_we = 1'b0; acc_we = 1'b0; div_start = 1'b0;
    wr_addr = rd_idx; pal_wd = '0;
    rs_wd = '0; gs_wd = '0; bs_wd = '0; hc_wd = '0;
    rd_addr = IW'(scan);
    unique case (state)
      S_CLEAR: begin
        acc_we = 1'b1; wr_addr = IW'(scan);
      end
      S_IDLE: begin
        if (accept && req.data.command == CMD_WRITE &&
            32'(req.data.entry_index) < PALETTE_ENTRIES) begin
          pal_we = 1'b1; wr_addr = IW'(req.data.entry_index);
          pal_wd = {req.data.red, req.data.green, req.data.blue};
        end
      end
      S_ACC: begin
        acc_we = 1'b1; wr_addr = best_idx;
        rs_wd = rs_q + 24'(cur.red);
        gs_wd = gs_q + 24'(cur.green);
        bs_wd = bs_q + 24'(cur.blue);
        hc_wd = hc_q + 16'd1;
      end
      // hold the entry address while the pixel waits to go out
      S_EXRD, S_EXOUT: rd_addr = IW'(ex_idx);
      S_DECIDE: rd_addr = best_idx;
      S_UDIV: div_start = (hc_q != 16'd0) && !div_run && rd_valid;
      S_UWR: begin
        pal_we = 1'b1;
        pal_wd = (hc_q == 16'd0) ?
          {pal_q[23:16] + 8'h10, pal_q[15:8] + 8'h10, pal_q[7:0] + 8'h10} : avg;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      scan       <= '0;
      depth      <= 4'd1;
      width      <= 13'd8;
      out_valid  <= 1'b0;
      samples    <= '0;
      pack_shift <= '0;
      pack_pos   <= '0;
      line_pos   <= '0;
      rd_valid   <= 1'b0;
      div_run    <= 1'b0;
    end else begin
      if (res.valid && res.ready) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_DEPTH) depth <= cfg_data[3:0];
        else width <= cfg_data;
        pack_shift <= '0; pack_pos <= '0; line_pos <= '0;
      end
      unique case (state)
        S_CLEAR: begin
          scan <= scan + 9'd1;
          if (32'(scan) == PALETTE_ENTRIES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cur <= req.data;
            scan <= '0; slot <= '0;
            best_ok <= 1'b0; best_idx <= '0;
            rd_valid <= 1'b0;
            unique case (req.data.command)
              CMD_CLASSIFY: state <= S_SCAN;
              CMD_TRAIN:    if (samples != 16'hFFFF) state <= S_SCAN;
              CMD_UPDATE:   state <= S_URD;
              CMD_EXPAND:   state <= S_EXRD;
              default: ;
            endcase
          end
        end
        // one entry per cycle: address issued, compared in the next cycle
        S_SCAN: begin
          scan <= scan + 9'd1;
          rd_idx <= IW'(scan);
          rd_valid <= 1'b1;
          if (rd_valid && (!best_ok || sq_dist < best)) begin
            best <= sq_dist; best_ok <= 1'b1; best_idx <= rd_idx;
          end
          if (scan == active - 9'd1) state <= S_SCANW;
        end
        S_SCANW: begin
          rd_valid <= 1'b0;
          if (!best_ok || sq_dist < best) best_idx <= rd_idx;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          rd_idx <= best_idx;
          if (cur.command == CMD_TRAIN) state <= S_ACC;
          else begin
            if (pp_next >= spb || eol) begin
              out_reg <= '{kind: KIND_PACKED,
                packed_out: pk_next << ((spb - pp_next) * bits),
                out_red: 8'd0, out_green: 8'd0, out_blue: 8'd0, last: eol};
              out_valid  <= 1'b1;
              pack_shift <= '0;
              pack_pos   <= '0;
              line_pos   <= eol ? '0 : lp_next;
            end else begin
              pack_shift <= pk_next;
              pack_pos   <= pp_next;
              line_pos   <= lp_next;
            end
            state <= S_IDLE;
          end
        end
        S_ACC: begin
          samples <= samples + 16'd1;
          state <= S_IDLE;
        end
        S_EXRD: state <= S_EXOUT;
        S_EXOUT: begin
          if (!out_valid) begin
            out_reg <= '{kind: KIND_PIXEL, packed_out: 8'd0,
              out_red: (32'(ex_idx) < PALETTE_ENTRIES) ? pal_q[23:16] : 8'd0,
              out_green: (32'(ex_idx) < PALETTE_ENTRIES) ? pal_q[15:8] : 8'd0,
              out_blue: (32'(ex_idx) < PALETTE_ENTRIES) ? pal_q[7:0] : 8'd0,
              last: (slot + 4'd1 == spb)};
            out_valid <= 1'b1;
            slot <= slot + 4'd1;
            state <= (slot + 4'd1 == spb) ? S_IDLE : S_EXRD;
          end
        end
        S_URD: begin
          rd_idx <= IW'(scan); chan <= 2'd0; rd_valid <= 1'b0;
          state <= S_UDIV;
        end
        // one division per channel, started once and awaited; none for an entry with no hits
        S_UDIV: begin
          rd_valid <= 1'b1;
          if (div_start) div_run <= 1'b1;
          if (rd_valid && hc_q == 16'd0) state <= S_UWR;
          else if (div_done) begin
            div_run <= 1'b0;
            unique case (chan)
              2'd0:    avg[23:16] <= div_q;
              2'd1:    avg[15:8]  <= div_q;
              default: avg[7:0]   <= div_q;
            endcase
            if (chan == 2'd2) state <= S_UWR;
            else chan <= chan + 2'd1;
          end
        end
        S_UWR: begin
          if (scan == active - 9'd1) begin
            scan <= '0; state <= S_WAIT;
          end else begin
            scan <= scan + 9'd1; state <= S_URD;
          end
        end
        S_WAIT: begin
          // report done, then clear accumulators
          if (!out_valid) begin
            out_reg <= '{kind: KIND_DONE, packed_out: 8'd0,
              out_red: 8'd0, out_green: 8'd0, out_blue: 8'd0, last: 1'b0};
            out_valid <= 1'b1;
            samples <= '0;
            state <= S_CLEAR;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_pack_bound: assert property (@(posedge clk) disable iff (rst)
    pack_pos < spb || pack_pos == 4'd0) else $error("pack position overflow");
  a_sample_cap: assert property (@(posedge clk) disable iff (rst)
    $past(samples) == 16'hFFFF && state != S_CLEAR |-> samples == 16'hFFFF ||
    samples == 16'd0) else $error("sample budget exceeded");
endmodule
`default_nettype wire

// File: design/pqr_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqr_divider: radix-2 restoring divider
// Divides a 24-bit sum by a 16-bit count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pqr_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [23:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [7:0]       quotient
);
  logic [4:0]  count;
  logic        busy;
  logic [23:0] quo;
  logic [16:0] rem;
  logic [16:0] trial;
  logic [15:0] dsr;

  assign trial    = {rem[15:0], quo[23]} - {1'b0, dsr};
  assign quotient = quo[7:0];

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 5'd0;
      quo   <= dividend;
      rem   <= '0;
      dsr   <= divisor;
      done  <= 1'b0;
    end else if (busy) begin
      if (!trial[16]) begin
        rem <= trial;
        quo <= {quo[22:0], 1'b1};
      end else begin
        rem <= {rem[15:0], quo[23]};
        quo <= {quo[22:0], 1'b0};
      end
      count <= count + 5'd1;
      done  <= (count == 5'd23);
      if (count == 5'd23) busy <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end
endmodule
`default_nettype wire
